FILE: design/lcdfmt_pkg.sv
`default_nettype none

package lcdfmt_pkg;

  // Widths of the register and payload fields
  localparam int unsigned COL_W  = 6;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned CNT_W  = 2;

  localparam int unsigned MAX_WIDTH_DEF = 40;
  localparam int unsigned QUEUE_DEPTH   = 2;

  // Operation codes on the input channel
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_GOTO  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic REG_LINE_WIDTH = 1'b0;
  localparam logic REG_LINE_COUNT = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CMD_CLEAR  = 8'h01;

  localparam logic [COL_W-1:0] LINE_W_RST     = 6'd16;
  localparam logic [CNT_W-1:0] LINE_COUNT_RST = 2'd2;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_NEWLINE,
    KIND_GOTO,
    KIND_CLEAR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  col;
    logic              row;
  } cmd_t;

endpackage

`default_nettype wire

FILE: design/lcdfmt_front.sv
`default_nettype none

module lcdfmt_front import lcdfmt_pkg::*; (
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        op_i,
  input  wire logic [CHAR_W-1:0] char_code_i,
  input  wire logic [COL_W-1:0]  target_col_i,
  input  wire logic              target_row_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output cmd_t                   q_cmd_o
);

  logic      op_known;
  cmd_kind_e kind;

  always_comb begin
    op_known = 1'b1;
    kind     = KIND_CHAR;
    case (op_i)
      OP_PUT: begin
        if (char_code_i inside {CHAR_LF, CHAR_CR}) begin
          kind = KIND_NEWLINE;
        end else begin
          kind = KIND_CHAR;
        end
      end
      OP_GOTO:  kind = KIND_GOTO;
      OP_CLEAR: kind = KIND_CLEAR;
      default:  op_known = 1'b0;
    endcase
  end

  // Unknown opcodes are taken and dropped without touching the queue
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && op_known;

  assign q_cmd_o.kind      = kind;
  assign q_cmd_o.char_code = char_code_i;
  assign q_cmd_o.col       = target_col_i;
  assign q_cmd_o.row       = target_row_i;

endmodule

`default_nettype wire

FILE: design/lcdfmt_queue.sv
`default_nettype none

module lcdfmt_queue import lcdfmt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output cmd_t      pop_cmd_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  cmd_t            entries_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;

  assign full_o    = (count_q == (PtrW+1)'(QUEUE_DEPTH));
  assign empty_o   = (count_q == '0);
  assign pop_cmd_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/lcdfmt_back.sv
`default_nettype none

module lcdfmt_back import lcdfmt_pkg::*; #(
  parameter int unsigned MaxWidth = MAX_WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [COL_W-1:0]  line_width_i,
  input  wire logic [CNT_W-1:0]  line_count_i,
  input  wire logic              q_empty_i,
  input  wire cmd_t              q_cmd_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   is_data_o,
  output logic [CHAR_W-1:0]      lcd_byte_o,
  output logic                   last_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_ADDR = 3'd2;
  localparam logic [2:0] S_CHAR = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;

  localparam logic [COL_W:0] MaxW = (COL_W+1)'(MaxWidth);

  logic [2:0]        state_q, state_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              row_q, row_d;
  logic              scroll_q, scroll_d;
  logic [COL_W-1:0]  pad_q, pad_d;
  logic [COL_W-1:0]  acol_q, acol_d;
  logic              arow_q, arow_d;
  logic              addr_last_q, addr_last_d;
  logic              nl_q, nl_d;
  logic [CHAR_W-1:0] char_q, char_d;

  logic              out_valid_q, out_valid_d;
  logic              is_data_q, is_data_d;
  logic [CHAR_W-1:0] byte_q, byte_d;
  logic              last_q, last_d;

  logic [COL_W:0] eff_w;
  logic           can_emit;
  logic           next_row;
  logic           need_scroll;

  always_comb begin
    if ({1'b0, line_width_i} > MaxW) begin
      eff_w = MaxW;
    end else begin
      eff_w = {1'b0, line_width_i};
    end
  end

  assign can_emit    = !out_valid_q || out_ready_i;
  assign next_row    = !row_q && (line_count_i >= 2'd2);
  assign need_scroll = scroll_q || ({1'b0, col_q} >= eff_w);
  assign q_pop_o     = (state_q == S_IDLE) && !q_empty_i;

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    scroll_d    = scroll_q;
    pad_d       = pad_q;
    acol_d      = acol_q;
    arow_d      = arow_q;
    addr_last_d = addr_last_q;
    nl_d        = nl_q;
    char_d      = char_q;
    out_valid_d = out_valid_q && !out_ready_i;
    is_data_d   = is_data_q;
    byte_d      = byte_q;
    last_d      = last_q;

    case (state_q)
      S_IDLE: begin
        if (q_pop_o) begin
          char_d      = q_cmd_i.char_code;
          nl_d        = 1'b0;
          addr_last_d = 1'b1;
          case (q_cmd_i.kind)
            KIND_NEWLINE: begin
              pad_d   = col_q;
              acol_d  = col_q;
              arow_d  = row_q;
              nl_d    = 1'b1;
              state_d = S_PAD;
            end
            KIND_CHAR: begin
              if (need_scroll) begin
                pad_d       = col_q;
                acol_d      = '0;
                arow_d      = next_row;
                addr_last_d = 1'b0;
                state_d     = S_PAD;
              end else begin
                state_d = S_CHAR;
              end
            end
            KIND_GOTO: begin
              acol_d  = q_cmd_i.col;
              arow_d  = q_cmd_i.row;
              state_d = S_ADDR;
            end
            KIND_CLEAR: begin
              acol_d  = '0;
              arow_d  = 1'b0;
              state_d = S_CLR;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_PAD: begin
        // Fill the rest of the line with spaces, then move on to the address
        if ({1'b0, pad_q} < eff_w) begin
          if (can_emit) begin
            out_valid_d = 1'b1;
            is_data_d   = 1'b1;
            byte_d      = CHAR_SPACE;
            last_d      = 1'b0;
            pad_d       = pad_q + 1'b1;
          end
        end else begin
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          is_data_d   = 1'b0;
          byte_d      = {1'b1, arow_q, acol_q};
          last_d      = addr_last_q;
          col_d       = acol_q;
          row_d       = arow_q;
          scroll_d    = nl_q;
          state_d     = addr_last_q ? S_IDLE : S_CHAR;
        end
      end
      S_CHAR: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          is_data_d   = 1'b1;
          byte_d      = char_q;
          last_d      = 1'b1;
          col_d       = col_q + 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_CLR: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          is_data_d   = 1'b0;
          byte_d      = CMD_CLEAR;
          last_d      = 1'b0;
          state_d     = S_ADDR;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      row_q       <= 1'b0;
      scroll_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      scroll_q    <= scroll_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pad_q       <= pad_d;
    acol_q      <= acol_d;
    arow_q      <= arow_d;
    addr_last_q <= addr_last_d;
    nl_q        <= nl_d;
    char_q      <= char_d;
    is_data_q   <= is_data_d;
    byte_q      <= byte_d;
    last_q      <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign is_data_o   = is_data_q;
  assign lcd_byte_o  = byte_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

FILE: design/char_lcd_text_formatter.sv
`default_nettype none

// Character LCD text formatter. Each input beat is one text operation (put
// character, goto, clear) and produces the byte writes for a two-line
// character LCD controller, each flagged data or command, with last on the
// final write of the operation; opcode 3 is accepted and produces nothing.
// The front end classifies operations into a two-entry queue, so new beats
// are taken while earlier ones are still being written out. The back end
// sequencer emits at most one write per cycle through a registered output,
// held while ready is low: goto writes an address; clear a clear command
// then an address; a plain character the character; a newline padding
// spaces (up to the effective line width, at most MaxWidth) then an address;
// and a character that scrolls the padding, an address, then the character.
// Write the configuration registers only while the block is idle.

module char_lcd_text_formatter import lcdfmt_pkg::*; #(
  parameter int unsigned MaxWidth = MAX_WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        op_i,
  input  wire logic [CHAR_W-1:0] char_code_i,
  input  wire logic [COL_W-1:0]  target_col_i,
  input  wire logic              target_row_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   is_data_o,
  output logic [CHAR_W-1:0]      lcd_byte_o,
  output logic                   last_o,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_addr_i,
  input  wire logic [COL_W-1:0]  cfg_wdata_i
);

  logic [COL_W-1:0] line_width_q;
  logic [CNT_W-1:0] line_count_q;

  logic q_full, q_push, q_pop, q_empty;
  cmd_t push_cmd, pop_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LINE_W_RST;
      line_count_q <= LINE_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_LINE_WIDTH: line_width_q <= cfg_wdata_i;
        REG_LINE_COUNT: line_count_q <= cfg_wdata_i[CNT_W-1:0];
        default:        line_width_q <= line_width_q;
      endcase
    end
  end

  lcdfmt_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .char_code_i  (char_code_i),
    .target_col_i (target_col_i),
    .target_row_i (target_row_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (push_cmd)
  );

  lcdfmt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_cmd_o  (pop_cmd)
  );

  lcdfmt_back #(
    .MaxWidth (MaxWidth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .line_width_i (line_width_q),
    .line_count_i (line_count_q),
    .q_empty_i    (q_empty),
    .q_cmd_i      (pop_cmd),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .is_data_o    (is_data_o),
    .lcd_byte_o   (lcd_byte_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire
